// ----- rtl/core/gcm_pkg.sv -----
// Shared types and constants for the greedy change maker.
`default_nettype none
package gcm_pkg;

    localparam int NUM_DENOM_REGS = 6;
    localparam int DENOM_W        = 20;
    localparam int AMOUNT_W       = 32;
    localparam int CNT_W          = 3;
    localparam int BIT_W          = $clog2(AMOUNT_W);
    localparam int TDATA_IN_W     = 32;
    localparam int TDATA_OUT_W    = 88;

    typedef logic [DENOM_W-1:0]              t_denom;
    typedef t_denom [NUM_DENOM_REGS-1:0]     t_denom_set;

    typedef enum logic [2:0] {
        REG_DENOM_COUNT = 3'd0,
        REG_DENOM_A     = 3'd1,
        REG_DENOM_B     = 3'd2,
        REG_DENOM_C     = 3'd3,
        REG_DENOM_D     = 3'd4,
        REG_DENOM_E     = 3'd5,
        REG_DENOM_F     = 3'd6
    } t_reg_idx;

    localparam logic [CNT_W-1:0] DENOM_COUNT_RESET = 3'd6;
    localparam t_denom_set DENOM_RESET = {
        20'd10000, 20'd20000, 20'd50000, 20'd100000, 20'd200000, 20'd500000
    };

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

// ----- rtl/core/greedy_change_maker.sv -----
// Top level of the greedy change maker: register file, front end, queue, back end.
// Usage:
//   s_axis carries one withdrawal amount per transaction (tdata[31:0]).
//   m_axis returns one transaction per active denomination, largest first:
//   tdata holds denomination, note count and unpaid amount; tlast marks the
//   final transaction of a withdrawal, which alone carries a nonzero unpaid.
//   With no denominations in use a single transaction reports denomination 0.
//   The APB port holds the denomination count and six denominations; write
//   it only while no withdrawal is in flight.
// Operation:
//   The front end takes an amount, runs an odd-even transposition sort over the
//   denominations and then queues the job. The back end takes a job, then for
//   each denomination divides bit-serially over all 32 amount bits when the
//   denomination and the remainder are both nonzero, and emits the result. It
//   finishes one job before it takes the next; the two-entry queue decouples the
//   two, so the front end can accept a new amount meanwhile.
// Reset: synchronous, active low; restores the default denominations and empties
//   the queue and output stage. A stalled m_axis holds its result and backs up
//   into the queue, then into s_axis_tready.
`default_nettype none
module greedy_change_maker #(
    parameter int MAX_DENOMS = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] amount
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [19:0] denomination, [51:20] note_count,
                                        // [83:52] unpaid, [87:84] zero
    output logic        m_axis_tlast,   // last
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gcm_pkg::*;

    localparam int NUM_SLOTS = (MAX_DENOMS < NUM_DENOM_REGS) ? MAX_DENOMS : NUM_DENOM_REGS;
    localparam int JOB_W     = AMOUNT_W + CNT_W + NUM_SLOTS * DENOM_W;

    logic [CNT_W-1:0]    r_denom_count;
    t_denom_set          r_denoms;
    logic [2:0]          reg_idx;
    logic                wr_en;
    logic                push, pop;
    logic [JOB_W-1:0]    job_in, job_out;
    t_q_status           q_status;
    logic [DENOM_W-1:0]  out_denom;
    logic [AMOUNT_W-1:0] out_count;
    logic [AMOUNT_W-1:0] out_unpaid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_DENOM_COUNT: prdata = {29'd0, r_denom_count};
            REG_DENOM_A:     prdata = {12'd0, r_denoms[0]};
            REG_DENOM_B:     prdata = {12'd0, r_denoms[1]};
            REG_DENOM_C:     prdata = {12'd0, r_denoms[2]};
            REG_DENOM_D:     prdata = {12'd0, r_denoms[3]};
            REG_DENOM_E:     prdata = {12'd0, r_denoms[4]};
            REG_DENOM_F:     prdata = {12'd0, r_denoms[5]};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_denom_count <= DENOM_COUNT_RESET;
            r_denoms      <= DENOM_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DENOM_COUNT: r_denom_count <= pwdata[CNT_W-1:0];
                REG_DENOM_A:     r_denoms[0]   <= pwdata[DENOM_W-1:0];
                REG_DENOM_B:     r_denoms[1]   <= pwdata[DENOM_W-1:0];
                REG_DENOM_C:     r_denoms[2]   <= pwdata[DENOM_W-1:0];
                REG_DENOM_D:     r_denoms[3]   <= pwdata[DENOM_W-1:0];
                REG_DENOM_E:     r_denoms[4]   <= pwdata[DENOM_W-1:0];
                REG_DENOM_F:     r_denoms[5]   <= pwdata[DENOM_W-1:0];
                default:         r_denom_count <= r_denom_count;
            endcase
        end
    end

    gcm_front #(
        .NUM_SLOTS (NUM_SLOTS),
        .JOB_W     (JOB_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_amount      (s_axis_tdata[AMOUNT_W-1:0]),
        .i_denom_count (r_denom_count),
        .i_denoms      (r_denoms),
        .o_push        (push),
        .o_job         (job_in),
        .i_q_status    (q_status)
    );

    gcm_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (job_in),
        .i_pop       (pop),
        .o_data      (job_out),
        .o_status    (q_status)
    );

    gcm_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .JOB_W     (JOB_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_out),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .o_denomination (out_denom),
        .o_note_count   (out_count),
        .o_unpaid       (out_unpaid),
        .m_axis_tlast   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_unpaid, out_count, out_denom};

endmodule
`default_nettype wire

// ----- rtl/core/gcm_front.sv -----
// Front end: accepts a withdrawal, orders the active denominations, queues the job.
`default_nettype none
module gcm_front #(
    parameter int NUM_SLOTS = 6,
    parameter int JOB_W     = 155
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [gcm_pkg::AMOUNT_W-1:0]  i_amount,
    input  wire  [gcm_pkg::CNT_W-1:0]     i_denom_count,
    input  wire  gcm_pkg::t_denom_set     i_denoms,
    output logic                          o_push,
    output logic [JOB_W-1:0]              o_job,
    input  wire  gcm_pkg::t_q_status      i_q_status
);
    import gcm_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SORT = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state            r_state, n_state;
    logic [AMOUNT_W-1:0]     r_amount, n_amount;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [CNT_W-1:0]        r_pass, n_pass;
    t_denom_set              r_v, n_v;
    logic [CNT_W-1:0]        clamp6;
    logic [CNT_W-1:0]        n_active;
    logic [CNT_W-1:0]        n_job;
    logic [NUM_SLOTS-1:0][DENOM_W-1:0] job_list;

    always_comb begin
        clamp6   = (i_denom_count > CNT_W'(NUM_DENOM_REGS)) ? CNT_W'(NUM_DENOM_REGS)
                                                             : i_denom_count;
        n_active = (clamp6 > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : clamp6;
        n_job    = (r_n == '0) ? CNT_W'(1) : r_n;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            job_list[k] = r_v[k];
        end
    end

    assign s_axis_tready = (r_state == F_IDLE);
    assign o_push        = (r_state == F_PUSH) && !i_q_status.full;
    assign o_job         = {job_list, n_job, r_amount};

    always_comb begin
        n_state  = r_state;
        n_amount = r_amount;
        n_n      = r_n;
        n_pass   = r_pass;
        n_v      = r_v;
        unique case (r_state)
            F_IDLE: begin
                if (s_axis_tvalid) begin
                    n_amount = i_amount;
                    n_n      = n_active;
                    n_pass   = '0;
                    for (int k = 0; k < NUM_DENOM_REGS; k++) begin
                        n_v[k] = (CNT_W'(k) < n_active) ? i_denoms[k] : '0;
                    end
                    n_state = F_SORT;
                end
            end
            F_SORT: begin
                for (int k = 0; k < NUM_DENOM_REGS - 1; k++) begin
                    if ((k % 2) == int'(r_pass[0]) && (r_v[k] < r_v[k+1])) begin
                        n_v[k]   = r_v[k+1];
                        n_v[k+1] = r_v[k];
                    end
                end
                n_pass = r_pass + CNT_W'(1);
                if (r_pass == CNT_W'(NUM_DENOM_REGS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_status.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_amount <= n_amount;
        r_n      <= n_n;
        r_pass   <= n_pass;
        r_v      <= n_v;
    end

endmodule
`default_nettype wire

// ----- rtl/core/gcm_queue.sv -----
// Two-entry job queue between the front end and the back end.
`default_nettype none
module gcm_queue #(
    parameter int JOB_W = 155
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire  [JOB_W-1:0]   i_push_data,
    input  wire                i_pop,
    output logic [JOB_W-1:0]   o_data,
    output gcm_pkg::t_q_status o_status
);
    import gcm_pkg::*;

    logic [JOB_W-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/gcm_back.sv -----
// Back end: serial division per denomination and the registered result stage.
`default_nettype none
module gcm_back #(
    parameter int NUM_SLOTS = 6,
    parameter int JOB_W     = 155
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  [JOB_W-1:0]                  i_job,
    input  wire  gcm_pkg::t_q_status          i_q_status,
    output logic                              o_pop,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [gcm_pkg::DENOM_W-1:0]       o_denomination,
    output logic [gcm_pkg::AMOUNT_W-1:0]      o_note_count,
    output logic [gcm_pkg::AMOUNT_W-1:0]      o_unpaid,
    output logic                              m_axis_tlast
);
    import gcm_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_START = 4'b0010,
        B_DIV   = 4'b0100,
        B_EMIT  = 4'b1000
    } t_back_state;

    t_back_state                       r_state, n_state;
    logic [AMOUNT_W-1:0]               r_rem, n_rem;
    logic [AMOUNT_W-1:0]               r_quo, n_quo;
    logic [DENOM_W-1:0]                r_part, n_part;
    logic [BIT_W-1:0]                  r_bit, n_bit;
    logic [CNT_W-1:0]                  r_left, n_left;
    logic [NUM_SLOTS-1:0][DENOM_W-1:0] r_list, n_list;
    logic                              r_out_valid, n_out_valid;
    logic [DENOM_W-1:0]                r_out_denom, n_out_denom;
    logic [AMOUNT_W-1:0]               r_out_count, n_out_count;
    logic [AMOUNT_W-1:0]               r_out_unpaid, n_out_unpaid;
    logic                              r_out_last, n_out_last;
    logic [DENOM_W:0]                  trial;
    logic [DENOM_W:0]                  diff;
    logic                              ge;
    logic                              out_free;
    logic                              is_last;
    logic [DENOM_W-1:0]                d;

    assign d        = r_list[0];
    assign trial    = {r_part, r_quo[AMOUNT_W-1]};
    assign ge       = (trial >= {1'b0, d});
    assign diff     = trial - {1'b0, d};
    assign out_free = !r_out_valid || m_axis_tready;
    assign is_last  = (r_left == CNT_W'(1));
    assign o_pop    = (r_state == B_IDLE) && !i_q_status.empty;

    assign m_axis_tvalid  = r_out_valid;
    assign o_denomination = r_out_denom;
    assign o_note_count   = r_out_count;
    assign o_unpaid       = r_out_unpaid;
    assign m_axis_tlast   = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_part       = r_part;
        n_bit        = r_bit;
        n_left       = r_left;
        n_list       = r_list;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_denom  = r_out_denom;
        n_out_count  = r_out_count;
        n_out_unpaid = r_out_unpaid;
        n_out_last   = r_out_last;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_rem   = i_job[AMOUNT_W-1:0];
                    n_left  = i_job[AMOUNT_W +: CNT_W];
                    n_list  = i_job[AMOUNT_W+CNT_W +: NUM_SLOTS*DENOM_W];
                    n_state = B_START;
                end
            end
            B_START: begin
                if (d != '0 && r_rem != '0) begin
                    n_quo   = r_rem;
                    n_part  = '0;
                    n_bit   = '0;
                    n_state = B_DIV;
                end else begin
                    n_quo   = '0;
                    n_state = B_EMIT;
                end
            end
            B_DIV: begin
                n_part = ge ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
                n_quo  = {r_quo[AMOUNT_W-2:0], ge};
                n_bit  = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(AMOUNT_W - 1)) begin
                    n_rem   = AMOUNT_W'(n_part);
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_denom  = d;
                    n_out_count  = r_quo;
                    n_out_unpaid = is_last ? r_rem : '0;
                    n_out_last   = is_last;
                    n_list       = r_list >> DENOM_W;
                    n_left       = r_left - CNT_W'(1);
                    n_state      = is_last ? B_IDLE : B_START;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_part       <= n_part;
        r_bit        <= n_bit;
        r_left       <= n_left;
        r_list       <= n_list;
        r_out_denom  <= n_out_denom;
        r_out_count  <= n_out_count;
        r_out_unpaid <= n_out_unpaid;
        r_out_last   <= n_out_last;
    end

endmodule
`default_nettype wire

// ----- tb/tb_greedy_change_maker.sv -----
// Testbench for greedy_change_maker: streams withdrawal amounts and checks every payout.
`timescale 1ns / 1ps
module tb_greedy_change_maker;
    import gcm_pkg::*;

    localparam int          MAX_DENOMS  = 6;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          TAIL_CYCLES = 300;
    localparam logic [2:0]  REG_BEYOND  = 3'd7;

    typedef struct packed {
        t_denom      denom;
        logic [31:0] notes;
        logic [31:0] unpaid;
        logic        last;
    } payout_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // [31:0] amount
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;     // [19:0] denomination, [51:20] note_count, [83:52] unpaid
    logic        m_axis_tlast;     // last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [CNT_W-1:0] cfg_count;
    t_denom_set       cfg_denoms;
    payout_t          payouts_due[$];
    int               mismatches = 0;
    int               cycle_count = 0;
    int               source_idle_pct = 0;
    int               sink_idle_pct = 0;

    greedy_change_maker #(
        .MAX_DENOMS(MAX_DENOMS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("mismatch %0s: expected %0d, got %0d (t=%0t)", what, want, got, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_payouts
        payout_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (payouts_due.size() == 0) begin
                report_mismatch("transaction with none pending", 0, 1);
            end else begin
                want = payouts_due.pop_front();
                if (m_axis_tdata[19:0] !== want.denom)
                    report_mismatch("denomination", want.denom, m_axis_tdata[19:0]);
                if (m_axis_tdata[51:20] !== want.notes)
                    report_mismatch("note_count", want.notes, m_axis_tdata[51:20]);
                if (m_axis_tdata[83:52] !== want.unpaid)
                    report_mismatch("unpaid", want.unpaid, m_axis_tdata[83:52]);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", want.last, m_axis_tlast);
            end
        end
    end

    task automatic predict_payout(input logic [31:0] amount);
        t_denom      sorted [NUM_DENOM_REGS];
        t_denom      swap;
        payout_t     p;
        int          n;
        logic [31:0] rem;
        logic [31:0] notes;
        n = cfg_count;
        if (n > NUM_DENOM_REGS) n = NUM_DENOM_REGS;
        if (n > MAX_DENOMS) n = MAX_DENOMS;
        rem = amount;
        if (n == 0) begin
            p = '{denom: '0, notes: '0, unpaid: rem, last: 1'b1};
            payouts_due.push_back(p);
        end else begin
            for (int i = 0; i < n; i++) sorted[i] = cfg_denoms[i];
            for (int i = 0; i + 1 < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (sorted[i] < sorted[j]) begin
                        swap = sorted[i];
                        sorted[i] = sorted[j];
                        sorted[j] = swap;
                    end
            for (int i = 0; i < n; i++) begin
                notes = '0;
                if (sorted[i] != 0 && rem != 0) begin
                    notes = rem / {12'b0, sorted[i]};
                    rem = rem - notes * {12'b0, sorted[i]};
                end
                p = '{denom: sorted[i], notes: notes, unpaid: '0, last: 1'b0};
                if (i == n - 1) begin
                    p.unpaid = rem;
                    p.last = 1'b1;
                end
                payouts_due.push_back(p);
            end
        end
    endtask

    task automatic send_amount(input logic [31:0] amount);
        while ($urandom_range(0, 99) < source_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= amount;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_payout(amount);
    endtask

    task automatic wait_payouts_done();
        s_axis_tvalid <= 1'b0;
        while (payouts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        wait_payouts_done();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DENOM_COUNT)
            cfg_count = value[CNT_W-1:0];
        else if (idx <= REG_DENOM_F)
            cfg_denoms[idx - 3'd1] = value[DENOM_W-1:0];
    endtask

    task automatic write_denoms(input t_denom a, input t_denom b, input t_denom c,
                                input t_denom d, input t_denom e, input t_denom f);
        write_reg(REG_DENOM_A, {12'($urandom_range(0, 4095)), a});
        write_reg(REG_DENOM_B, {12'($urandom_range(0, 4095)), b});
        write_reg(REG_DENOM_C, {12'($urandom_range(0, 4095)), c});
        write_reg(REG_DENOM_D, {12'($urandom_range(0, 4095)), d});
        write_reg(REG_DENOM_E, {12'($urandom_range(0, 4095)), e});
        write_reg(REG_DENOM_F, {12'($urandom_range(0, 4095)), f});
    endtask

    task automatic test_default_denoms();
        send_amount(32'd0);
        send_amount(32'd1);
        send_amount(32'd880000);
        send_amount(32'd10000);
        send_amount(32'd9999);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'h8000_0000);
        wait_payouts_done();
    endtask

    task automatic test_no_denoms();
        write_reg(REG_DENOM_COUNT, {29'h1ABC_DEF0, 3'd0});
        send_amount(32'd12345);
        send_amount(32'd0);
        wait_payouts_done();
    endtask

    task automatic test_count_saturation();
        write_denoms(20'd7, 20'd300, 20'd11, 20'd5000, 20'd2, 20'd90);
        write_reg(REG_DENOM_COUNT, 32'd7);
        send_amount(32'd1234567);
        write_reg(REG_BEYOND, 32'hFFFF_FFFF);
        send_amount(32'd7654321);
        wait_payouts_done();
    endtask

    task automatic test_zero_and_equal_denoms();
        write_reg(REG_DENOM_COUNT, 32'd6);
        write_denoms(20'd0, 20'd700, 20'd700, 20'd0, 20'd1, 20'hFFFFF);
        send_amount(32'd3146430);
        send_amount(32'hFFFF_FFFF);
        send_amount(32'd699);
        wait_payouts_done();
    endtask

    task automatic test_partial_count();
        write_denoms(20'd3, 20'd7, 20'd5, 20'd1, 20'd1, 20'd1);
        write_reg(REG_DENOM_COUNT, 32'd3);
        send_amount(32'd100);
        send_amount(32'd1);
        write_reg(REG_DENOM_A, 32'd1);
        write_reg(REG_DENOM_COUNT, 32'd1);
        send_amount(32'hFFFF_FFFF);
        write_reg(REG_DENOM_A, 32'hFFFF_FFFF);
        send_amount(32'hFFFF_FFFF);
        wait_payouts_done();
    endtask

    task automatic load_random_denoms();
        t_denom     picks [NUM_DENOM_REGS];
        logic [2:0] count;
        for (int r = 0; r < NUM_DENOM_REGS; r++) begin
            case ($urandom_range(0, 9))
                0:       picks[r] = '0;
                1:       picks[r] = (r == 0) ? 20'd1 : picks[r-1];
                2, 3, 4: picks[r] = 20'($urandom_range(1, 1000));
                5, 6, 7: picks[r] = 20'($urandom_range(1000, 20'hFFFFF));
                8:       picks[r] = 20'($urandom());
                default: picks[r] = 20'hFFFFF;
            endcase
        end
        write_denoms(picks[0], picks[1], picks[2], picks[3], picks[4], picks[5]);
        case ($urandom_range(0, 9))
            0:       count = 3'd0;
            1:       count = 3'd7;
            default: count = 3'($urandom_range(1, 6));
        endcase
        write_reg(REG_DENOM_COUNT, {29'($urandom_range(0, 32'h1FFF_FFFF)), count});
    endtask

    function automatic logic [31:0] random_amount();
        logic [31:0] amount;
        case ($urandom_range(0, 9))
            0:       amount = '0;
            1, 2:    amount = $urandom_range(0, 5000);
            3, 4:    amount = cfg_denoms[$urandom_range(0, NUM_DENOM_REGS - 1)]
                              * $urandom_range(0, 4000) + $urandom_range(0, 3);
            default: amount = $urandom();
        endcase
        return amount;
    endfunction

    task automatic test_random_payouts();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin source_idle_pct = 9;  sink_idle_pct = 67; end
                1:       begin source_idle_pct = 67; sink_idle_pct = 9;  end
                default: begin source_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                load_random_denoms();
                for (int k = 0; k < 31; k++) send_amount(random_amount());
            end
        end
        wait_payouts_done();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        m_axis_tready = 1'b0;
        cfg_count     = DENOM_COUNT_RESET;
        cfg_denoms    = DENOM_RESET;
        source_idle_pct = 9;
        sink_idle_pct   = 67;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_denoms();
        test_no_denoms();
        test_count_saturation();
        test_zero_and_equal_denoms();
        test_partial_count();
        test_random_payouts();

        wait_payouts_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gcm_pkg.sv
rtl/core/gcm_front.sv
rtl/core/gcm_queue.sv
rtl/core/gcm_back.sv
rtl/core/greedy_change_maker.sv
tb/tb_greedy_change_maker.sv
